/* rtl/core/ssbs_pkg.sv */
// Shared types and codes for the serial SRAM burst sequencer.
package ssbs_pkg;

  // Burst phase, one-hot.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_WRITE = 3'b010,
    PH_READ  = 3'b100
  } phase_t;

  // Command codes.
  localparam logic [2:0] CMD_START_WR = 3'd0;
  localparam logic [2:0] CMD_START_RD = 3'd1;
  localparam logic [2:0] CMD_WR_WORD  = 3'd2;
  localparam logic [2:0] CMD_RD_WORD  = 3'd3;
  localparam logic [2:0] CMD_RX_BYTE  = 3'd4;
  localparam logic [2:0] CMD_END      = 3'd5;

  // Result kinds.
  localparam logic [2:0] KIND_XFER    = 3'd0;
  localparam logic [2:0] KIND_RD_WORD = 3'd1;
  localparam logic [2:0] KIND_RANGE   = 3'd2;
  localparam logic [2:0] KIND_SEQ     = 3'd3;
  localparam logic [2:0] KIND_RELEASE = 3'd4;

  // Chip selects.
  localparam logic [1:0] CHIP_NONE = 2'd0;
  localparam logic [1:0] CHIP_LO   = 2'd1;
  localparam logic [1:0] CHIP_HI   = 2'd2;

  // Serial memory bytes.
  localparam logic [7:0] INSTR_WRITE = 8'h02;
  localparam logic [7:0] INSTR_READ  = 8'h03;
  localparam logic [7:0] DUMMY_BYTE  = 8'h7E;

  // Config register indexes and resets.
  localparam logic REG_CHIP0_TOP = 1'b0;
  localparam logic REG_CHIP1_TOP = 1'b1;
  localparam logic [24:0] CHIP0_TOP_RST = 25'd131071;
  localparam logic [24:0] CHIP1_TOP_RST = 25'd262143;

  // Most results one command can cause.
  localparam int MAX_RES = 5;

endpackage

/* rtl/core/spi_sram_burst_sequencer.sv */
// Burst sequencer that frames byte transfers for two serial SRAMs.
//
// Usage:
//   Commands enter on the in_ channel (valid/ready). Each command is decoded
//   in one pass against the burst state and expands into zero to five result
//   words, which are held in a small batch register and handed one per cycle,
//   whenever the output register is empty or its word is taken, to the output
//   register that drives the out_ channel (valid/ready). out_last marks the
//   final word caused by a command. Each result word passes through the batch
//   register and then the output register. A read start causes five words, a
//   write start four, a write or read word two, and other commands one or none.
//   The next command is taken as the batch hands over its last word, so there
//   are no bubbles between commands while the receiver keeps out_ready high.
//   When the receiver stalls, the output word holds and the batch waits;
//   in_ready stays low until the batch can be refilled.
//   Config: APB-style port, chip0_top at byte address 0, chip1_top at 4.
//   Write it only while the block is idle.
//   Reset (rst_n low, synchronous) returns the burst phase to idle, drops
//   the chip select, clears pending read bytes and empties batch and output.
module spi_sram_burst_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [23:0] in_word_addr,
  input  logic [15:0] in_wdata,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic [1:0]  out_chip,
  output logic        out_clk_polarity,
  output logic        out_cpha,
  output logic [15:0] out_rdata,
  output logic        out_last,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  logic [24:0] chip0_top_r, chip0_top_nxt;
  logic [24:0] chip1_top_r, chip1_top_nxt;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    chip0_top_nxt = chip0_top_r;
    chip1_top_nxt = chip1_top_r;
    if (cfg_wr) begin
      case (paddr[2])
        ssbs_pkg::REG_CHIP0_TOP: chip0_top_nxt = pwdata[24:0];
        ssbs_pkg::REG_CHIP1_TOP: chip1_top_nxt = pwdata[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ssbs_pkg::REG_CHIP0_TOP: prdata = {7'd0, chip0_top_r};
      ssbs_pkg::REG_CHIP1_TOP: prdata = {7'd0, chip1_top_r};
      default:                 prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Burst state
  // ---------------------------------------------------------------------
  ssbs_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]       act_chip_r, act_chip_nxt;
  logic [7:0]       held_lo_r, held_lo_nxt;
  logic [1:0]       await_r, await_nxt;

  // ---------------------------------------------------------------------
  // Batch register: results of the last accepted command, not yet handed on
  // ---------------------------------------------------------------------
  logic [2:0]  b_rem_r, b_rem_nxt;
  logic [7:0]  b_tx_r [ssbs_pkg::MAX_RES];
  logic [7:0]  b_tx_nxt [ssbs_pkg::MAX_RES];
  logic [2:0]  b_kind_r, b_kind_nxt;
  logic [1:0]  b_chip_r, b_chip_nxt;
  logic        b_pol_r, b_pol_nxt;
  logic        b_pha_r, b_pha_nxt;
  logic [15:0] b_rdata_r, b_rdata_nxt;

  // Output register
  logic        o_valid_r, o_valid_nxt;
  logic [2:0]  o_kind_r, o_kind_nxt;
  logic [7:0]  o_tx_r, o_tx_nxt;
  logic [1:0]  o_chip_r, o_chip_nxt;
  logic        o_pol_r, o_pol_nxt;
  logic        o_pha_r, o_pha_nxt;
  logic [15:0] o_rdata_r, o_rdata_nxt;
  logic        o_last_r, o_last_nxt;

  logic move;    // batch head goes to the output register
  logic accept;

  assign move     = (b_rem_r != 3'd0) & (~o_valid_r | out_ready);
  assign in_ready = (b_rem_r == 3'd0) | ((b_rem_r == 3'd1) & move);
  assign accept   = in_valid & in_ready;

  // ---------------------------------------------------------------------
  // Decode pass: one command -> result batch and next burst state
  // ---------------------------------------------------------------------
  logic [24:0] dbl_addr;
  logic        in_rd;
  logic [2:0]  p_cnt;
  logic [7:0]  p_tx [ssbs_pkg::MAX_RES];
  logic [2:0]  p_kind;
  logic [1:0]  p_chip;
  logic        p_pol, p_pha;
  logic [15:0] p_rdata;
  ssbs_pkg::phase_t p_phase;
  logic [1:0]  p_act;
  logic [7:0]  p_held;
  logic [1:0]  p_await;
  logic [1:0]  sel_chip;
  logic        in_range;

  assign dbl_addr = {in_word_addr, 1'b0};
  assign in_rd    = (phase_r == ssbs_pkg::PH_READ);

  always_comb begin
    // chip pick against the two bounds
    sel_chip = ssbs_pkg::CHIP_NONE;
    in_range = 1'b1;
    if (dbl_addr <= chip0_top_r) begin
      sel_chip = ssbs_pkg::CHIP_LO;
    end else if (dbl_addr <= chip1_top_r) begin
      sel_chip = ssbs_pkg::CHIP_HI;
    end else begin
      in_range = 1'b0;
    end
  end

  always_comb begin
    // default: one sequence error with current select and mode
    p_cnt   = 3'd1;
    for (int i = 0; i < ssbs_pkg::MAX_RES; i++) begin
      p_tx[i] = 8'd0;
    end
    p_kind  = ssbs_pkg::KIND_SEQ;
    p_chip  = act_chip_r;
    p_pol   = ~in_rd;
    p_pha   = in_rd;
    p_rdata = 16'd0;
    p_phase = phase_r;
    p_act   = act_chip_r;
    p_held  = held_lo_r;
    p_await = await_r;

    case (in_cmd)
      ssbs_pkg::CMD_START_WR, ssbs_pkg::CMD_START_RD: begin
        if (phase_r != ssbs_pkg::PH_IDLE) begin
          p_kind = ssbs_pkg::KIND_SEQ;
        end else if (!in_range) begin
          p_kind = ssbs_pkg::KIND_RANGE;
        end else begin
          p_kind  = ssbs_pkg::KIND_XFER;
          p_chip  = sel_chip;
          p_pol   = 1'b1;
          p_pha   = 1'b0;
          p_act   = sel_chip;
          p_tx[1] = dbl_addr[23:16];
          p_tx[2] = dbl_addr[15:8];
          p_tx[3] = dbl_addr[7:0];
          if (in_cmd == ssbs_pkg::CMD_START_RD) begin
            p_cnt   = 3'd5;
            p_tx[0] = ssbs_pkg::INSTR_READ;
            p_tx[4] = ssbs_pkg::DUMMY_BYTE;
            p_phase = ssbs_pkg::PH_READ;
            p_await = 2'd0;
          end else begin
            p_cnt   = 3'd4;
            p_tx[0] = ssbs_pkg::INSTR_WRITE;
            p_phase = ssbs_pkg::PH_WRITE;
          end
        end
      end
      ssbs_pkg::CMD_WR_WORD: begin
        if (phase_r == ssbs_pkg::PH_WRITE) begin
          p_cnt   = 3'd2;
          p_kind  = ssbs_pkg::KIND_XFER;
          p_tx[0] = in_wdata[7:0];   // low byte first
          p_tx[1] = in_wdata[15:8];
        end
      end
      ssbs_pkg::CMD_RD_WORD: begin
        if (in_rd && (await_r == 2'd0)) begin
          p_cnt   = 3'd2;
          p_kind  = ssbs_pkg::KIND_XFER;
          p_tx[0] = ssbs_pkg::DUMMY_BYTE;
          p_tx[1] = ssbs_pkg::DUMMY_BYTE;
          p_await = 2'd2;
        end
      end
      ssbs_pkg::CMD_RX_BYTE: begin
        if (in_rd && (await_r == 2'd2)) begin
          p_cnt   = 3'd0;              // first byte held, no result
          p_held  = in_rx_byte;
          p_await = 2'd1;
        end else if (in_rd && (await_r != 2'd0)) begin
          p_kind  = ssbs_pkg::KIND_RD_WORD;
          p_rdata = {in_rx_byte, held_lo_r};
          p_await = 2'd0;
        end
      end
      ssbs_pkg::CMD_END: begin
        if (phase_r != ssbs_pkg::PH_IDLE) begin
          p_kind  = ssbs_pkg::KIND_RELEASE;
          p_chip  = ssbs_pkg::CHIP_NONE;
          p_pol   = 1'b1;
          p_pha   = 1'b0;
          p_phase = ssbs_pkg::PH_IDLE;
          p_act   = ssbs_pkg::CHIP_NONE;
          p_await = 2'd0;
        end
      end
      default: ;  // unused codes: sequence error
    endcase
  end

  // ---------------------------------------------------------------------
  // Next-state: burst state, batch, output register
  // ---------------------------------------------------------------------
  always_comb begin
    phase_nxt    = phase_r;
    act_chip_nxt = act_chip_r;
    held_lo_nxt  = held_lo_r;
    await_nxt    = await_r;
    b_rem_nxt    = b_rem_r;
    b_kind_nxt   = b_kind_r;
    b_chip_nxt   = b_chip_r;
    b_pol_nxt    = b_pol_r;
    b_pha_nxt    = b_pha_r;
    b_rdata_nxt  = b_rdata_r;
    for (int i = 0; i < ssbs_pkg::MAX_RES; i++) begin
      b_tx_nxt[i] = b_tx_r[i];
    end

    if (move) begin
      // shift the byte queue toward the head
      b_rem_nxt = b_rem_r - 3'd1;
      for (int i = 0; i < ssbs_pkg::MAX_RES - 1; i++) begin
        b_tx_nxt[i] = b_tx_r[i + 1];
      end
    end

    if (accept) begin
      phase_nxt    = p_phase;
      act_chip_nxt = p_act;
      held_lo_nxt  = p_held;
      await_nxt    = p_await;
      b_rem_nxt    = p_cnt;
      b_kind_nxt   = p_kind;
      b_chip_nxt   = p_chip;
      b_pol_nxt    = p_pol;
      b_pha_nxt    = p_pha;
      b_rdata_nxt  = p_rdata;
      for (int i = 0; i < ssbs_pkg::MAX_RES; i++) begin
        b_tx_nxt[i] = p_tx[i];
      end
    end
  end

  always_comb begin
    o_kind_nxt  = o_kind_r;
    o_tx_nxt    = o_tx_r;
    o_chip_nxt  = o_chip_r;
    o_pol_nxt   = o_pol_r;
    o_pha_nxt   = o_pha_r;
    o_rdata_nxt = o_rdata_r;
    o_last_nxt  = o_last_r;
    o_valid_nxt = o_valid_r & ~out_ready;
    if (move) begin
      o_valid_nxt = 1'b1;
      o_kind_nxt  = b_kind_r;
      o_tx_nxt    = b_tx_r[0];
      o_chip_nxt  = b_chip_r;
      o_pol_nxt   = b_pol_r;
      o_pha_nxt   = b_pha_r;
      o_rdata_nxt = b_rdata_r;
      o_last_nxt  = (b_rem_r == 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip0_top_r <= ssbs_pkg::CHIP0_TOP_RST;
      chip1_top_r <= ssbs_pkg::CHIP1_TOP_RST;
      phase_r     <= ssbs_pkg::PH_IDLE;
      act_chip_r  <= ssbs_pkg::CHIP_NONE;
      await_r     <= 2'd0;
      b_rem_r     <= 3'd0;
      o_valid_r   <= 1'b0;
    end else begin
      chip0_top_r <= chip0_top_nxt;
      chip1_top_r <= chip1_top_nxt;
      phase_r     <= phase_nxt;
      act_chip_r  <= act_chip_nxt;
      await_r     <= await_nxt;
      b_rem_r     <= b_rem_nxt;
      o_valid_r   <= o_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    held_lo_r <= held_lo_nxt;
    b_kind_r  <= b_kind_nxt;
    b_chip_r  <= b_chip_nxt;
    b_pol_r   <= b_pol_nxt;
    b_pha_r   <= b_pha_nxt;
    b_rdata_r <= b_rdata_nxt;
    for (int i = 0; i < ssbs_pkg::MAX_RES; i++) begin
      b_tx_r[i] <= b_tx_nxt[i];
    end
    o_kind_r  <= o_kind_nxt;
    o_tx_r    <= o_tx_nxt;
    o_chip_r  <= o_chip_nxt;
    o_pol_r   <= o_pol_nxt;
    o_pha_r   <= o_pha_nxt;
    o_rdata_r <= o_rdata_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign out_valid        = o_valid_r;
  assign out_kind         = o_kind_r;
  assign out_tx_byte      = o_tx_r;
  assign out_chip         = o_chip_r;
  assign out_clk_polarity = o_pol_r;
  assign out_cpha         = o_pha_r;
  assign out_rdata        = o_rdata_r;
  assign out_last         = o_last_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // idle means no chip selected
  a_idle_no_chip: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ssbs_pkg::PH_IDLE) |-> (act_chip_r == ssbs_pkg::CHIP_NONE))
    else $error("chip selected while idle");

  // pending read bytes only inside a read burst
  a_await_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    (await_r != 2'd0) |-> (phase_r == ssbs_pkg::PH_READ))
    else $error("bytes awaited outside read burst");

  // batch never holds more than a read start produces
  a_batch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    b_rem_r <= 3'd5)
    else $error("batch overflow");

  // a new command only lands once the batch is empty or hands over its last word
  a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ((b_rem_r == 3'd0) || ((b_rem_r == 3'd1) && move)))
    else $error("command accepted over pending results");

  // a handed-over word that is not the last is followed by more batch
  a_last_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (move && (b_rem_r != 3'd1)) |=> (b_rem_r != 3'd0))
    else $error("batch drained before last word");

endmodule
